// ===== rtl/dbpf_pkg.sv =====
// Shared constants, types and address helper for the double-buffered page frame buffer.
`timescale 1ns / 1ps
`default_nettype none
package dbpf_pkg;

	localparam int COLUMNS     = 128;
	localparam int PAGES       = 8;
	localparam int STORE_BYTES = COLUMNS * PAGES;
	localparam int DEPTH       = 2048;
	localparam int ADDR_W      = 11;
	localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int PAGE_W      = 3;
	localparam int SLOT_W      = $clog2(COLUMNS + 3);
	localparam int SLOT_END    = COLUMNS + 3;

	localparam logic [1:0] OP_DRAW = 2'd0;
	localparam logic [1:0] OP_SWAP = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_SLOT = 2'd3;

	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_LO = 8'h00;
	localparam logic [7:0] CMD_COL_HI = 8'h10;

	typedef struct packed {
		logic              emit;
		logic              is_data;
		logic              last;
		logic [7:0]        cmd;
		logic [PAGE_W-1:0] page;
		logic [COL_W-1:0]  col;
	} scan_out_t;

	function automatic logic [ADDR_W-1:0] store_addr(input logic sel,
			input logic [PAGE_W-1:0] page, input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] base;
		begin
			base = sel ? ADDR_W'(STORE_BYTES) : '0;
			return base + ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col);
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dbpf_scan.sv =====
// Refresh sequencer: page, slot and pending tracking for the panel link stream.
`timescale 1ns / 1ps
`default_nettype none
module dbpf_scan
	import dbpf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      tick,
	input  wire logic      step,
	output scan_out_t      scan
);

	logic              active_q;
	logic              refresh_q;
	logic [PAGE_W-1:0] page_q;
	logic [SLOT_W-1:0] slot_q;

	logic [PAGE_W-1:0] page;
	logic [SLOT_W-1:0] slot;
	logic [SLOT_W-1:0] slot_nxt;
	logic              wrap;
	logic              last;

	always_comb begin
		page     = active_q ? page_q : '0;
		slot     = active_q ? slot_q : '0;
		slot_nxt = slot + SLOT_W'(1);
		wrap     = (slot_nxt == SLOT_W'(SLOT_END));
		last     = wrap && (page == PAGE_W'(PAGES - 1));

		scan.emit    = active_q | refresh_q;
		scan.is_data = (slot >= SLOT_W'(3));
		scan.last    = last;
		scan.page    = page;
		scan.col     = COL_W'(slot - SLOT_W'(3));
		unique case (slot)
			SLOT_W'(0): scan.cmd = CMD_PAGE | 8'(page);
			SLOT_W'(1): scan.cmd = CMD_COL_LO;
			SLOT_W'(2): scan.cmd = CMD_COL_HI;
			default:    scan.cmd = CMD_COL_LO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			refresh_q <= 1'b0;
			page_q    <= '0;
			slot_q    <= '0;
		end else if (tick) begin
			refresh_q <= 1'b1;
		end else if (step && scan.emit) begin
			if (last) begin
				active_q  <= 1'b0;
				refresh_q <= 1'b0;
				page_q    <= '0;
				slot_q    <= '0;
			end else if (wrap) begin
				active_q <= 1'b1;
				page_q   <= page + PAGE_W'(1);
				slot_q   <= '0;
			end else begin
				active_q <= 1'b1;
				page_q   <= page;
				slot_q   <= slot_nxt;
			end
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < SLOT_W'(SLOT_END))
		else $error("scan slot beyond page end");

	a_active_pending: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> refresh_q)
		else $error("refresh running without pending mark");

	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (slot_q == '0 && page_q == '0))
		else $error("idle sequencer not at page 0 slot 0");

endmodule
`default_nettype wire

// ===== rtl/double_buffered_page_framebuffer_top.sv =====
// Top level of the double-buffered page frame buffer with its frame store memory.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+--------------------------------------
//  command   | start in, busy out         | opcode, pixel_x, pixel_y, pixel_on
//  result    | strobe out (one cycle)     | out_byte, is_data, frame_last
//
// A draw or a link data slot reads the frame store at the accepting edge; in the
// following cycle the modified byte is written back (draw) or the result is presented on
// strobe (link slot). busy is high for that cycle of every accepted transaction, so a new
// transaction is accepted only once the previous one is finished.
// After reset a clearing pass writes zero to all 2048 store entries, one per cycle;
// busy stays high until the pass is done.
// The receiver cannot stall: every result appears for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module double_buffered_page_framebuffer_top
	import dbpf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] opcode,
	input  wire logic [6:0] pixel_x,
	input  wire logic [5:0] pixel_y,
	input  wire logic       pixel_on,
	output logic            strobe,
	output logic [7:0]      out_byte,
	output logic            is_data,
	output logic            frame_last
);

	// Frame store: two page-organized 1-bit images, back and front.
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	logic              clear_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic front_q;
	logic swap_q;

	logic accept;
	logic is_draw;
	logic is_slot;
	logic draw_ok;
	logic [PAGE_W-1:0] draw_page;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_en;

	scan_out_t scan;

	// Registered context of the accepted transaction.
	logic              valid_s1;
	logic              draw_s1;
	logic              emit_s1;
	logic              is_data_s1;
	logic              last_s1;
	logic [7:0]        cmd_s1;
	logic [ADDR_W-1:0] wa_s1;
	logic [7:0]        mask_s1;
	logic              on_s1;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [7:0]        mem_wd;

	assign busy    = clear_q | valid_s1;
	assign accept  = start && !busy;
	assign is_draw = (opcode == OP_DRAW);
	assign is_slot = (opcode == OP_SLOT);

	// Drop draws that land outside the panel.
	assign draw_page = pixel_y[5:3];
	assign draw_ok   = (8'(pixel_x) < 8'(COLUMNS)) && (4'(draw_page) < 4'(PAGES));

	dbpf_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (accept && (opcode == OP_TICK)),
		.step   (accept && is_slot),
		.scan   (scan)
	);

	// Draw reads the back store; a link slot reads the front store.
	always_comb begin
		if (is_draw) begin
			rd_addr = store_addr(~front_q, draw_page, COL_W'(pixel_x));
			rd_en   = accept && draw_ok;
		end else begin
			rd_addr = store_addr(front_q, scan.page, scan.col);
			rd_en   = accept && is_slot && scan.emit && scan.is_data;
		end
	end

	// One write port: clearing pass after reset, then read-modify-write of draws.
	always_comb begin
		if (clear_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = 8'h00;
		end else begin
			mem_we = valid_s1 && draw_s1;
			mem_wa = wa_s1;
			mem_wd = on_s1 ? (rd_q | mask_s1) : (rd_q & ~mask_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Clearing pass: sweep every entry once, hold off commands until done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// Swap request and front-store selection; a tick exchanges the stores when a swap is pending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= 1'b0;
			swap_q  <= 1'b0;
		end else if (accept) begin
			if (opcode == OP_SWAP) begin
				swap_q <= 1'b1;
			end else if (opcode == OP_TICK && swap_q) begin
				front_q <= ~front_q;
				swap_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			draw_s1  <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			draw_s1  <= accept && is_draw && draw_ok;
			emit_s1  <= accept && is_slot && scan.emit;
		end
	end

	// Registered payload of the accepted transaction: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			is_data_s1 <= scan.is_data;
			last_s1    <= scan.last;
			cmd_s1     <= scan.cmd;
			wa_s1      <= rd_addr;
			mask_s1    <= 8'b1 << pixel_y[2:0];
			on_s1      <= pixel_on;
		end
	end

	assign strobe     = valid_s1 && emit_s1;
	assign out_byte   = is_data_s1 ? rd_q : cmd_s1;
	assign is_data    = is_data_s1;
	assign frame_last = last_s1;

	a_no_result_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !strobe)
		else $error("result during clearing pass");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accepted transaction");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && frame_last) |-> is_data)
		else $error("frame_last on a command byte");

	a_write_not_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && draw_s1) |-> !accept)
		else $error("write-back overlaps a new transaction");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the double-buffered page frame buffer top level.
`timescale 1ns / 1ps
module tb_top;
	import dbpf_pkg::*;

	// Stop here if the run hangs: the clearing pass plus ~2000 transactions
	// with idle gaps fits many times over.
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_ITEMS = 1950;
	localparam int unsigned DRAIN_CYCLES = 8;

	// One link byte as the panel sees it.
	typedef struct packed {
		logic [7:0] val;
		logic       is_data;
		logic       last;
	} link_byte_t;

	// One directed command, with the link byte typed in where it is obvious.
	typedef struct packed {
		logic [1:0] op;
		logic [6:0] x;
		logic [5:0] y;
		logic       lit;
		logic       has_exp;
		link_byte_t want;
	} cmd_row_t;

	localparam int DIRECTED_ROWS = 18;
	localparam cmd_row_t DIRECTED[DIRECTED_ROWS] = '{
		// link slot with nothing pending: no byte
		'{OP_SLOT, 7'd0,   6'd0,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		// draw into the back store (store 1): corners, then set/clear one bit
		'{OP_DRAW, 7'd0,   6'd0,  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_DRAW, 7'd127, 6'd63, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_DRAW, 7'd5,   6'd9,  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_DRAW, 7'd5,   6'd9,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_DRAW, 7'd5,   6'd10, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		// swap, then tick: store 1 goes to the front and a refresh is due
		'{OP_SWAP, 7'd0,   6'd0,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_TICK, 7'd0,   6'd0,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		// page header commands, then the first data byte
		'{OP_SLOT, 7'd0,   6'd0,  1'b0, 1'b1, '{CMD_PAGE,   1'b0, 1'b0}},
		'{OP_SLOT, 7'd0,   6'd0,  1'b0, 1'b1, '{CMD_COL_LO, 1'b0, 1'b0}},
		'{OP_SLOT, 7'd0,   6'd0,  1'b0, 1'b1, '{CMD_COL_HI, 1'b0, 1'b0}},
		'{OP_SLOT, 7'd0,   6'd0,  1'b0, 1'b1, '{8'h01, 1'b1, 1'b0}},
		// tick in the middle of a refresh is lost
		'{OP_TICK, 7'd0,   6'd0,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		// draw into store 0, swap mid-refresh: the rest streams from store 0
		'{OP_DRAW, 7'd1,   6'd0,  1'b1, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_SWAP, 7'd0,   6'd0,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_TICK, 7'd0,   6'd0,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}},
		'{OP_SLOT, 7'd0,   6'd0,  1'b0, 1'b1, '{8'h01, 1'b1, 1'b0}},
		'{OP_SLOT, 7'd0,   6'd0,  1'b0, 1'b0, '{8'h00, 1'b0, 1'b0}}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] opcode = OP_DRAW;
	logic [6:0] pixel_x = '0;
	logic [5:0] pixel_y = '0;
	logic       pixel_on = 1'b0;
	logic       busy;
	logic       strobe;
	logic [7:0] out_byte;
	logic       is_data;
	logic       frame_last;

	double_buffered_page_framebuffer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.pixel_on  (pixel_on),
		.strobe    (strobe),
		.out_byte  (out_byte),
		.is_data   (is_data),
		.frame_last(frame_last)
	);

	// Shadow copy of the panel state, updated at every accepted transaction.
	logic [7:0]  frame_mem [0:DEPTH-1];
	logic        show_sel = 1'b0;
	logic        swap_req = 1'b0;
	logic        refresh_due = 1'b0;
	logic        scanning = 1'b0;
	int unsigned scan_pg = 0;
	int unsigned scan_pos = 0;

	// Link bytes still owed by the block, oldest first.
	link_byte_t  link_bytes_due[$];
	int unsigned errors = 0;
	int unsigned cycle_count = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			frame_mem[i] = 8'h00;
		end
	end

	// Apply one command to the shadow state; return the link byte it sends, if any.
	task automatic panel_step(input logic [1:0] op, input logic [6:0] x,
			input logic [5:0] y, input logic lit, output bit emits,
			output link_byte_t res);
		int unsigned addr;
		int unsigned pg;
		begin
			emits = 1'b0;
			res = '0;
			case (op)
				OP_DRAW: begin
					pg = y >> 3;
					// out-of-range pixels are dropped
					if (x < COLUMNS && pg < PAGES) begin
						addr = (show_sel ? 0 : STORE_BYTES) + pg * COLUMNS + x;
						if (lit)
							frame_mem[addr] = frame_mem[addr] | (8'h01 << y[2:0]);
						else
							frame_mem[addr] = frame_mem[addr] & ~(8'h01 << y[2:0]);
					end
				end
				OP_SWAP: begin
					swap_req = 1'b1;
				end
				OP_TICK: begin
					refresh_due = 1'b1;
					if (swap_req) begin
						show_sel = ~show_sel;
						swap_req = 1'b0;
					end
				end
				OP_SLOT: begin
					// an idle link starts a refresh and sends its first byte now
					if (!scanning && refresh_due) begin
						scanning = 1'b1;
						scan_pg = 0;
						scan_pos = 0;
					end
					if (scanning) begin
						emits = 1'b1;
						if (scan_pos == 0)
							res.val = CMD_PAGE | 8'(scan_pg & 15);
						else if (scan_pos == 1)
							res.val = CMD_COL_LO;
						else if (scan_pos == 2)
							res.val = CMD_COL_HI;
						else begin
							addr = (show_sel ? STORE_BYTES : 0) + scan_pg * COLUMNS
								+ (scan_pos - 3);
							res.val = frame_mem[addr];
							res.is_data = 1'b1;
						end
						scan_pos++;
						if (scan_pos >= COLUMNS + 3) begin
							scan_pos = 0;
							scan_pg++;
							if (scan_pg >= PAGES) begin
								res.last = 1'b1;
								scan_pg = 0;
								scanning = 1'b0;
								refresh_due = 1'b0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	endtask

	// Drive one command transaction from a falling edge and hold it until accepted.
	// Optionally idle first. Return at the falling edge after acceptance.
	task automatic issue_command(input cmd_row_t row, input bit may_idle);
		bit         emits;
		link_byte_t res;
		begin
			if (may_idle) begin
				while ($urandom_range(0, 99) < 10) begin
					start <= 1'b0;
					@(negedge clk);
				end
			end
			start <= 1'b1;
			opcode <= row.op;
			pixel_x <= row.x;
			pixel_y <= row.y;
			pixel_on <= row.lit;
			// the transaction goes through at the first edge that sees busy low
			do begin
				@(posedge clk);
			end while (busy !== 1'b0);
			panel_step(row.op, row.x, row.y, row.lit, emits, res);
			if (emits)
				link_bytes_due.push_back(row.has_exp ? row.want : res);
			@(negedge clk);
		end
	endtask

	// Stimulus: reset, directed table, then random traffic weighted toward link slots.
	initial begin
		cmd_row_t row;
		int unsigned pick;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			issue_command(DIRECTED[i], 1'b1);
		end

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			row = '0;
			if (pick < 30)
				row.op = OP_DRAW;
			else if (pick < 35)
				row.op = OP_SWAP;
			else if (pick < 40)
				row.op = OP_TICK;
			else
				row.op = OP_SLOT;
			row.x = 7'($urandom_range(0, COLUMNS - 1));
			row.y = 6'($urandom_range(0, PAGES * 8 - 1));
			row.lit = 1'($urandom_range(0, 1));
			// keep a long burst back to back, idle at random elsewhere
			issue_command(row, !(n >= 600 && n < 1000));
		end
		start <= 1'b0;

		// drain the outstanding link bytes, then idle before the verdict
		while (link_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Compare every strobed link byte with the oldest one owed.
	always @(posedge clk) begin
		link_byte_t want;
		if (arst_n && strobe !== 1'b0) begin
			if (link_bytes_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected link byte: expected none, actual %h/%b/%b",
					$time, out_byte, is_data, frame_last);
			end else begin
				want = link_bytes_due.pop_front();
				if (out_byte !== want.val) begin
					errors++;
					$display("%0t: out_byte mismatch: expected %h, actual %h",
						$time, want.val, out_byte);
				end
				if (is_data !== want.is_data) begin
					errors++;
					$display("%0t: is_data mismatch: expected %b, actual %b",
						$time, want.is_data, is_data);
				end
				if (frame_last !== want.last) begin
					errors++;
					$display("%0t: frame_last mismatch: expected %b, actual %b",
						$time, want.last, frame_last);
				end
			end
		end
	end

	// Watchdog: end a hung run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d link bytes outstanding",
				$time, link_bytes_due.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

endmodule

// ===== files.f =====
rtl/dbpf_pkg.sv
rtl/dbpf_scan.sv
rtl/double_buffered_page_framebuffer_top.sv
verif/tb_top.sv
